// ===== rtl/cmh_pkg.sv =====
package cmh_pkg;

    // fixed field widths
    localparam int BASE_W     = 8;
    localparam int LINE_LEN_W = 32;
    localparam int MIN_LEN_W  = 8;
    localparam int LIMIT_W    = 16;
    localparam int CNT_W      = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT      = 1'd1;

    localparam logic [MIN_LEN_W-1:0] MIN_LINE_LENGTH_RST = 8'd31;
    localparam logic [LIMIT_W-1:0]   STOP_LIMIT_RST      = 16'd65000;

    // base coding: two bits taken from the character, complement flips the upper bit
    localparam logic [1:0] COMP_XOR = 2'd2;

    // saturation value of a histogram count
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [MIN_LEN_W-1:0] min_line_length;
        logic [LIMIT_W-1:0]   stop_limit;
    } t_cfg;

endpackage

// ===== rtl/cmh_in_if.sv =====
interface cmh_in_if;
    logic                                valid;
    logic                                ready;
    logic [cmh_pkg::BASE_W-1:0]          base;
    logic                                line_start;
    logic [cmh_pkg::LINE_LEN_W-1:0]      line_length;

    modport source (output valid, output base, output line_start, output line_length,
                    input ready);
    modport sink   (input valid, input base, input line_start, input line_length,
                    output ready);
endinterface

// ===== rtl/cmh_out_if.sv =====
interface cmh_out_if #(
    parameter int MMER_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic [MMER_BITS-1:0]          canonical_mmer;
    logic [cmh_pkg::CNT_W-1:0]     count;
    logic                          counted;
    logic                          halted;

    modport source (output valid, output canonical_mmer, output count, output counted,
                    output halted, input ready);
    modport sink   (input valid, input canonical_mmer, input count, input counted,
                    input halted, output ready);
endinterface

// ===== rtl/cmh_front.sv =====
module cmh_front #(
    parameter int MMER_LEN = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cmh_in_if.sink                        i_in_ch,
    input  cmh_pkg::t_cfg                 i_cfg,
    input  logic                          i_busy,
    input  logic                          i_push_ready,
    output logic                          o_push,
    output logic [2*MMER_LEN:0]           o_push_data
);

    localparam int MB     = 2 * MMER_LEN;
    localparam int SEEN_W = $clog2(MMER_LEN + 1);
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(MMER_LEN);

    logic [MB-1:0]     r_fwd, n_fwd;
    logic [MB-1:0]     r_rev, n_rev;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_line_en, n_line_en;

    logic [1:0]        code;
    logic [1:0]        comp;
    logic [MB-1:0]     fwd_base;
    logic [MB-1:0]     rev_base;
    logic [SEEN_W-1:0] seen_base;
    logic [MB-1:0]     canon;
    logic              counted;
    logic              accept;

    assign i_in_ch.ready = i_push_ready && !i_busy;
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    // shift the new base into both m-mers, a line start restarts them
    always_comb begin
        code = i_in_ch.base[2:1];
        comp = code ^ cmh_pkg::COMP_XOR;
        if (i_in_ch.line_start) begin
            fwd_base  = '0;
            rev_base  = '0;
            seen_base = '0;
            n_line_en = i_in_ch.line_length >=
                        cmh_pkg::LINE_LEN_W'(i_cfg.min_line_length);
        end else begin
            fwd_base  = r_fwd;
            rev_base  = r_rev;
            seen_base = r_seen;
            n_line_en = r_line_en;
        end
        n_fwd   = {fwd_base[MB-3:0], code};
        n_rev   = {comp, rev_base[MB-1:2]};
        n_seen  = (seen_base < SEEN_FULL) ? seen_base + 1'b1 : seen_base;
        counted = n_line_en && (n_seen == SEEN_FULL);
        canon   = (n_fwd < n_rev) ? n_fwd : n_rev;
    end

    // rolling state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd     <= '0;
            r_rev     <= '0;
            r_seen    <= '0;
            r_line_en <= 1'b0;
        end else if (accept) begin
            r_fwd     <= n_fwd;
            r_rev     <= n_rev;
            r_seen    <= n_seen;
            r_line_en <= n_line_en;
        end
    end

    assign o_push      = accept;
    assign o_push_data = {counted, canon};

endmodule

// ===== rtl/cmh_queue.sv =====
module cmh_queue #(
    parameter int WIDTH = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_push_data,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_data
);

    localparam int DEPTH = cmh_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_valid      = r_count != '0;
    assign o_data       = r_mem[r_rd_ptr];

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // fill level follows the push and pop strobes
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue fill level did not grow on a lone push");

endmodule

// ===== rtl/cmh_back.sv =====
module cmh_back #(
    parameter int MMER_LEN = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmh_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  logic [2*MMER_LEN:0]           i_q_data,
    output logic                          o_q_pop,
    output logic                          o_busy,
    cmh_out_if.source                     o_out_ch
);

    localparam int MB = 2 * MMER_LEN;
    localparam longint unsigned DEPTH = 64'(1) << MB;
    localparam int CW = cmh_pkg::CNT_W;

    // histogram
    logic [CW-1:0] r_mem [DEPTH];

    // clearing sweep after reset
    logic          r_clr_busy;
    logic [MB-1:0] r_clr_addr;

    // read stage
    logic          r_r_valid;
    logic [MB-1:0] r_r_canon;
    logic          r_r_counted;
    logic [CW-1:0] r_rdata;
    logic          r_fwd_valid;
    logic [MB-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_data;

    // output stage
    logic          r_o_valid;
    logic [MB-1:0] r_o_canon;
    logic [CW-1:0] r_o_count;
    logic          r_o_counted;
    logic          r_o_halted;

    logic          r_stopped;

    logic          o_take;
    logic          o_free;
    logic          r_move;
    logic          r_free;
    logic          q_pop;
    logic          do_count;
    logic          do_write;
    logic [CW-1:0] base_cnt;
    logic [CW-1:0] inc_cnt;
    logic          new_stop;

    // stage handshakes
    assign o_take  = r_o_valid && o_out_ch.ready;
    assign o_free  = !r_o_valid || o_take;
    assign r_move  = r_r_valid && o_free;
    assign r_free  = !r_r_valid || r_move;
    assign q_pop   = i_q_valid && r_free && !r_clr_busy;
    assign o_q_pop = q_pop;
    assign o_busy  = r_clr_busy;

    // increment with forwarding from the write made as this item was read
    always_comb begin
        base_cnt = (r_fwd_valid && (r_fwd_addr == r_r_canon)) ? r_fwd_data : r_rdata;
        inc_cnt  = (base_cnt == cmh_pkg::CNT_MAX) ? base_cnt : base_cnt + 1'b1;
        do_count = r_r_counted && !r_stopped;
        do_write = r_move && do_count;
        new_stop = do_write && (inc_cnt > i_cfg.stop_limit);
    end

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // histogram memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (do_write) begin
            r_mem[r_r_canon] <= inc_cnt;
        end
        if (q_pop) begin
            r_rdata <= r_mem[i_q_data[MB-1:0]];
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (q_pop) begin
            r_r_valid   <= 1'b1;
            r_fwd_valid <= do_write;
        end else if (r_move) begin
            r_r_valid   <= 1'b0;
        end
    end

    // read stage payload and forwarded write
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_r_canon   <= i_q_data[MB-1:0];
            r_r_counted <= i_q_data[MB];
            r_fwd_addr  <= r_r_canon;
            r_fwd_data  <= inc_cnt;
        end
    end

    // output stage and halt flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            if (r_move) begin
                r_o_valid <= 1'b1;
            end else if (o_take) begin
                r_o_valid <= 1'b0;
            end
            if (new_stop) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_move) begin
            r_o_canon   <= do_count ? r_r_canon : '0;
            r_o_count   <= do_count ? inc_cnt : '0;
            r_o_counted <= do_count;
            r_o_halted  <= r_stopped || new_stop;
        end
    end

    assign o_out_ch.valid          = r_o_valid;
    assign o_out_ch.canonical_mmer = r_o_canon;
    assign o_out_ch.count          = r_o_count;
    assign o_out_ch.counted        = r_o_counted;
    assign o_out_ch.halted         = r_o_halted;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_stopped)) |-> r_stopped)
        else $error("halt flag dropped without reset");

    // nothing leaves the queue while the histogram is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !q_pop)
        else $error("item taken during clearing sweep");

    // a counted result reports halt exactly when its count passed the limit
    a_halt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_counted) |-> (r_o_halted == (r_o_count > i_cfg.stop_limit)))
        else $error("halt flag disagrees with counted result");

endmodule

// ===== rtl/canonical_mmer_histogram_core.sv =====
// Canonical m-mer histogram core.
// i_in_ch carries one base character per item with line_start and line_length;
// o_out_ch returns one item per input item: the canonical m-mer, its count after
// the increment, whether it was counted, and the halt flag. Both channels use
// valid/ready; an item moves on a rising edge with both high.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while the
// core is idle; the user must keep to this, the core does not enforce it. Index 0
// is the minimum line length, index 1 the stop limit. Throughput is one item per
// cycle when the output is not stalled. An accepted item passes the queue, the
// read stage and the output register before its result shows on o_out_ch; the
// histogram update is a read-modify-write over a registered memory read with
// forwarding of the write made in the previous cycle, so back-to-back hits on one
// m-mer keep the rate. After reset the histogram is swept to zero, one entry per
// cycle, over all 4**MMER_LEN entries; i_in_ch.ready stays low during the sweep.
// When the receiver stalls, the output register holds its item, the read stage and
// a four-entry queue fill up, and only then does i_in_ch.ready drop. Once a count
// exceeds the stop limit every later item returns counted=0 and halted=1 until the next reset.
module canonical_mmer_histogram_core #(
    parameter int MMER_LEN = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    cmh_in_if.sink                               i_in_ch,
    cmh_out_if.source                            o_out_ch,
    input  logic                                 i_cfg_we,
    input  logic [cmh_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cmh_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int MB = 2 * MMER_LEN;

    cmh_pkg::t_cfg r_cfg, n_cfg;

    logic          push;
    logic [MB:0]   push_data;
    logic          push_ready;
    logic          q_valid;
    logic [MB:0]   q_data;
    logic          q_pop;
    logic          busy;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cmh_pkg::CFG_MIN_LINE_LENGTH: begin
                    n_cfg.min_line_length = i_cfg_wdata[cmh_pkg::MIN_LEN_W-1:0];
                end
                cmh_pkg::CFG_STOP_LIMIT: begin
                    n_cfg.stop_limit = i_cfg_wdata[cmh_pkg::LIMIT_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_line_length <= cmh_pkg::MIN_LINE_LENGTH_RST;
            r_cfg.stop_limit      <= cmh_pkg::STOP_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cmh_front #(
        .MMER_LEN (MMER_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .i_cfg        (r_cfg),
        .i_busy       (busy),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    cmh_queue #(
        .WIDTH (MB + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_data       (q_data)
    );

    cmh_back #(
        .MMER_LEN (MMER_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_busy    (busy),
        .o_out_ch  (o_out_ch)
    );

endmodule

// ===== verif/tb_canonical_mmer_histogram_core.sv =====
`timescale 1ns / 1ps

module tb_canonical_mmer_histogram_core;

    localparam int MMER_LEN        = 10;
    localparam int MMER_BITS       = 2 * MMER_LEN;
    // the histogram sweep after reset dominates the longest quiet stretch
    localparam int WATCHDOG_LIMIT  = 3 * (1 << MMER_BITS);
    localparam int SETTLE_CYCLES   = 32;
    localparam int IDLE_PCT        = 16;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int HOLD_OFF_AFTER  = 250;
    localparam int REPEAT_RUN      = 60;
    localparam int MAX_REPORTS     = 100;

    typedef logic [MMER_BITS-1:0] t_mmer;

    typedef struct packed {
        t_mmer                     mmer;
        logic [cmh_pkg::CNT_W-1:0] count;
        logic                      counted;
        logic                      halted;
    } t_tally_result;

    // predicts one result per base and checks results in order
    class t_mmer_scoreboard;
        logic [cmh_pkg::MIN_LEN_W-1:0] min_len;
        logic [cmh_pkg::LIMIT_W-1:0]   limit;
        t_mmer                         fwd;
        t_mmer                         rev;
        int unsigned                   seen;
        logic                          enabled;
        logic                          stopped;
        logic [cmh_pkg::CNT_W-1:0]     tally [int unsigned];
        t_tally_result                 pending [$];
        int unsigned                   errors;

        function new();
            min_len = cmh_pkg::MIN_LINE_LENGTH_RST;
            limit   = cmh_pkg::STOP_LIMIT_RST;
            fwd     = '0;
            rev     = '0;
            seen    = 0;
            enabled = 1'b0;
            stopped = 1'b0;
            errors  = 0;
        endfunction

        function void note_base(logic [cmh_pkg::BASE_W-1:0] base, logic line_start,
                                logic [cmh_pkg::LINE_LEN_W-1:0] line_length);
            logic [1:0]                code;
            logic [1:0]                comp;
            t_mmer                     canon;
            logic [cmh_pkg::CNT_W-1:0] cnt;
            t_tally_result             res;
            code       = base[2:1];
            comp       = code ^ cmh_pkg::COMP_XOR;
            res        = '0;
            res.halted = stopped;
            // halted: state frozen, nothing counted
            if (!stopped) begin
                // new line clears the window and decides if the line counts
                if (line_start) begin
                    fwd     = '0;
                    rev     = '0;
                    seen    = 0;
                    enabled = (line_length >= min_len);
                end
                fwd = {fwd[MMER_BITS-3:0], code};
                rev = {comp, rev[MMER_BITS-1:2]};
                if (seen < MMER_LEN)
                    seen++;
                // full window on an enabled line: bump the canonical m-mer
                if (enabled && seen >= MMER_LEN) begin
                    canon = (fwd < rev) ? fwd : rev;
                    cnt   = tally.exists(canon) ? tally[canon] : '0;
                    if (cnt != cmh_pkg::CNT_MAX)
                        cnt++;
                    tally[canon] = cnt;
                    if (cnt > limit)
                        stopped = 1'b1;
                    res.mmer    = canon;
                    res.count   = cnt;
                    res.counted = 1'b1;
                    res.halted  = stopped;
                end
            end
            pending = {pending, res};
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_tally_result got);
            t_tally_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item mmer=%h count=%0d counted=%b halted=%b",
                                 got.mmer, got.count, got.counted, got.halted));
                return;
            end
            want = pending.pop_front();
            if (got.mmer !== want.mmer || got.count !== want.count ||
                got.counted !== want.counted || got.halted !== want.halted) begin
                report($sformatf("got mmer=%h count=%0d counted=%b halted=%b, want %h %0d %b %b",
                                 got.mmer, got.count, got.counted, got.halted,
                                 want.mmer, want.count, want.counted, want.halted));
            end
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we;
    logic [cmh_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [cmh_pkg::CFG_DATA_W-1:0] cfg_wdata;

    cmh_in_if                           in_ch();
    cmh_out_if #(.MMER_BITS(MMER_BITS)) out_ch();

    t_mmer_scoreboard sb;
    bit               steady;
    bit               held_off = 1'b0;
    int unsigned      items_in;
    int unsigned      quiet = 0;

    canonical_mmer_histogram_core #(
        .MMER_LEN(MMER_LEN)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random nucleotide letter, upper or lower case
    function automatic logic [cmh_pkg::BASE_W-1:0] pick_nucleotide();
        string letters;
        letters = "ACGTacgt";
        return letters[$urandom_range(7)];
    endfunction

    // offer one base item and wait until it is taken
    task automatic send_item(input logic [cmh_pkg::BASE_W-1:0] base, input logic line_start,
                             input logic [cmh_pkg::LINE_LEN_W-1:0] line_length);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.base        <= base;
        in_ch.line_start  <= line_start;
        in_ch.line_length <= line_length;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_base(base, line_start, line_length);
        items_in++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input string seq,
                             input logic [cmh_pkg::LINE_LEN_W-1:0] line_length);
        for (int i = 0; i < seq.len(); i++)
            send_item(seq[i], i == 0, (i == 0) ? line_length : $urandom());
    endtask

    // mostly well-formed lines, some repetitive, some with junk bytes
    task automatic send_random_line();
        int unsigned                    n;
        int unsigned                    period;
        logic                           noisy;
        logic [cmh_pkg::LINE_LEN_W-1:0] len;
        logic [cmh_pkg::BASE_W-1:0]     motif [4];
        logic [cmh_pkg::BASE_W-1:0]     b;
        n      = ($urandom_range(9) == 0) ? $urandom_range(1, MMER_LEN - 1)
                                          : $urandom_range(MMER_LEN, 48);
        noisy  = ($urandom_range(4) == 0);
        period = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < 4; i++)
            motif[i] = pick_nucleotide();
        // reported length: true length, random, or around the minimum
        case ($urandom_range(5))
            0:       len = $urandom();
            1:       len = sb.min_len - 1;
            2:       len = sb.min_len;
            3:       len = sb.min_len + 1;
            default: len = n;
        endcase
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(3) == 0)
                b = 8'($urandom_range(255));
            else if (period != 0)
                b = motif[i % period];
            else
                b = pick_nucleotide();
            if (i == 0)
                send_item(b, 1'b1, len);
            else if (noisy && $urandom_range(15) == 0)
                send_item(b, 1'b1, $urandom());
            else
                send_item(b, 1'b0, $urandom());
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = items_in + count;
        while (items_in < target)
            send_random_line();
    endtask

    // stop offering and wait for every expected item to come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_config(input logic [cmh_pkg::MIN_LEN_W-1:0] min_len,
                              input logic [cmh_pkg::LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_idx   <= cmh_pkg::CFG_MIN_LINE_LENGTH;
        cfg_wdata <= {{(cmh_pkg::CFG_DATA_W - cmh_pkg::MIN_LEN_W){1'b0}}, min_len};
        @(negedge i_clk);
        cfg_idx   <= cmh_pkg::CFG_STOP_LIMIT;
        cfg_wdata <= limit;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.min_len = min_len;
        sb.limit   = limit;
    endtask

    // receiver: random stalls, one long hold-off, a stretch with none
    initial begin
        int unsigned hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && items_in >= HOLD_OFF_AFTER) begin
                hold     = HOLD_OFF_CYCLES;
                held_off = 1'b1;
            end
            if (hold != 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.canonical_mmer, out_ch.count, out_ch.counted,
                             out_ch.halted});
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("** canonical_mmer_histogram_core: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial begin
        sb                = new();
        cfg_we            = 1'b0;
        cfg_idx           = cmh_pkg::CFG_MIN_LINE_LENGTH;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.base        = '0;
        in_ch.line_start  = 1'b0;
        in_ch.line_length = '0;
        steady            = 1'b0;
        items_in          = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // base before any line, all ones byte
        send_item(8'hFF, 1'b0, 32'h0);
        // length equal to the minimum, then one more base past the window
        send_line("ACGTTGCAAC", 32'd31);
        send_item(8'h00, 1'b0, 32'h0);
        // enabled line too short for a full window
        send_line("GAT", 32'hFFFF_FFFF);
        // length one below the minimum: full window but nothing counted
        send_line("CCCCCCCCCC", 32'd30);
        wait_drained();

        // smallest minimum, near-top limit; second half with no idling
        set_config(8'd0, 16'd65534);
        run_random(90);
        steady = 1'b1;
        run_random(70);
        steady = 1'b0;
        wait_drained();

        // largest minimum
        set_config(8'd255, 16'($urandom_range(1000, 65000)));
        run_random(150);
        wait_drained();

        // top limit: hammer one m-mer in a long run, with random idles between items
        set_config(8'($urandom_range(1, 254)), 16'hFFFF);
        run_random(100);
        for (int i = 0; i < REPEAT_RUN; i++)
            send_item(($urandom_range(1) == 0) ? "A" : "a", i == 0, 32'hFFFF_FFFF);
        wait_drained();

        // zero limit: the first count halts, the rest come back halted
        set_config(8'($urandom_range(0, 40)), 16'd0);
        run_random(50);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0)
            $display("** canonical_mmer_histogram_core: PASSED **");
        else
            $display("** canonical_mmer_histogram_core: FAILED **");
        $finish;
    end

endmodule
